### rtl/core/ofd_pkg.sv
// Shared constants, register codes and interface structs of the occupancy frontier detector.
package ofd_pkg;

  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;

  localparam int unsigned CELL_W    = 8;
  localparam int unsigned DIM_W     = 11;
  localparam int unsigned IN_ROW_W  = 11;
  localparam int unsigned COLUMN_W  = 10;
  localparam int unsigned ROW_W     = 10;
  localparam int unsigned COL_W     = $clog2(MAX_WIDTH);
  localparam int unsigned LINE_W    = 2 * CELL_W;
  localparam int unsigned PADDR_W   = 4;
  localparam int unsigned PDATA_W   = 32;

  typedef enum logic [1:0] {
    REG_MAP_WIDTH    = 2'd0,
    REG_MAP_HEIGHT   = 2'd1,
    REG_UNKNOWN_CODE = 2'd2,
    REG_FREE_CODE    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [CELL_W-1:0] unknown_code;
    logic [CELL_W-1:0] free_code;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [COL_W-1:0]  col;
    logic [CELL_W-1:0] value;
    logic              due;
  } scan_t;

endpackage

### rtl/core/ofd_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module ofd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem_r [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/ofd_cfg.sv
// Configuration register file with an APB-style access port and clamped map dimensions.
module ofd_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [ofd_pkg::PADDR_W-1:0]  cfg_paddr,
  input  logic [ofd_pkg::PDATA_W-1:0]  cfg_pwdata,
  output logic [ofd_pkg::PDATA_W-1:0]  cfg_prdata,
  output logic                         cfg_pready,
  output ofd_pkg::cfg_t                cfg
);

  logic [ofd_pkg::DIM_W-1:0]  map_width_r;
  logic [ofd_pkg::DIM_W-1:0]  map_height_r;
  logic [ofd_pkg::CELL_W-1:0] unknown_code_r;
  logic [ofd_pkg::CELL_W-1:0] free_code_r;
  ofd_pkg::cfg_reg_t          reg_sel;
  logic                       wr_en;

  assign cfg_pready = 1'b1;
  assign reg_sel    = ofd_pkg::cfg_reg_t'(cfg_paddr[3:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r    <= ofd_pkg::DIM_W'(ofd_pkg::MAX_WIDTH);
      map_height_r   <= ofd_pkg::DIM_W'(ofd_pkg::MAX_HEIGHT);
      unknown_code_r <= '1;
      free_code_r    <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        ofd_pkg::REG_MAP_WIDTH:    map_width_r    <= cfg_pwdata[ofd_pkg::DIM_W-1:0];
        ofd_pkg::REG_MAP_HEIGHT:   map_height_r   <= cfg_pwdata[ofd_pkg::DIM_W-1:0];
        ofd_pkg::REG_UNKNOWN_CODE: unknown_code_r <= cfg_pwdata[ofd_pkg::CELL_W-1:0];
        ofd_pkg::REG_FREE_CODE:    free_code_r    <= cfg_pwdata[ofd_pkg::CELL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      ofd_pkg::REG_MAP_WIDTH:    cfg_prdata = ofd_pkg::PDATA_W'(map_width_r);
      ofd_pkg::REG_MAP_HEIGHT:   cfg_prdata = ofd_pkg::PDATA_W'(map_height_r);
      ofd_pkg::REG_UNKNOWN_CODE: cfg_prdata = ofd_pkg::PDATA_W'(unknown_code_r);
      ofd_pkg::REG_FREE_CODE:    cfg_prdata = ofd_pkg::PDATA_W'(free_code_r);
      default:                   cfg_prdata = '0;
    endcase
  end

  // A zero dimension counts as one and an oversized one is clamped to the buffer size.
  always_comb begin
    if (map_width_r == '0) begin
      cfg.width = ofd_pkg::DIM_W'(1);
    end else if (map_width_r > ofd_pkg::DIM_W'(ofd_pkg::MAX_WIDTH)) begin
      cfg.width = ofd_pkg::DIM_W'(ofd_pkg::MAX_WIDTH);
    end else begin
      cfg.width = map_width_r;
    end
    if (map_height_r == '0) begin
      cfg.height = ofd_pkg::DIM_W'(1);
    end else if (map_height_r > ofd_pkg::DIM_W'(ofd_pkg::MAX_HEIGHT)) begin
      cfg.height = ofd_pkg::DIM_W'(ofd_pkg::MAX_HEIGHT);
    end else begin
      cfg.height = map_height_r;
    end
    cfg.unknown_code = unknown_code_r;
    cfg.free_code    = free_code_r;
  end

endmodule

### rtl/core/ofd_window.sv
// 3x3 window, frontier test, output raster counters and the output register.
module ofd_window (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ofd_pkg::cfg_t                 cfg,
  input  ofd_pkg::scan_t                s1,
  input  logic [ofd_pkg::LINE_W-1:0]    col_data,
  output logic                          s1_ready,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [ofd_pkg::COLUMN_W-1:0]  out_column,
  output logic [ofd_pkg::ROW_W-1:0]     out_row,
  output logic                          out_is_frontier
);

  logic [ofd_pkg::CELL_W-1:0]   win_r   [9];
  logic [ofd_pkg::CELL_W-1:0]   win_nxt [9];
  logic [ofd_pkg::COL_W-1:0]    ocol_r, ocol_nxt;
  logic [ofd_pkg::DIM_W-1:0]    orow_r, orow_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [ofd_pkg::COLUMN_W-1:0] out_column_r;
  logic [ofd_pkg::ROW_W-1:0]    out_row_r;
  logic                         out_frontier_r;
  logic                         fire;
  logic                         produce;
  logic                         col_last;
  logic                         top_ok, bot_ok, left_ok, right_ok;
  logic                         frontier;

  assign s1_ready = !(out_valid_r && out_stall);
  assign fire     = s1.valid && s1_ready;
  assign produce  = fire && s1.due && (orow_r < cfg.height);

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[r*3]     = win_r[r*3+1];
      win_nxt[r*3 + 1] = win_r[r*3+2];
    end
    win_nxt[2] = col_data[ofd_pkg::LINE_W-1:ofd_pkg::CELL_W];
    win_nxt[5] = col_data[ofd_pkg::CELL_W-1:0];
    win_nxt[8] = s1.value;
  end

  assign col_last = (ofd_pkg::DIM_W'(ocol_r) + ofd_pkg::DIM_W'(1)) >= cfg.width;
  assign top_ok   = orow_r != '0;
  assign bot_ok   = (orow_r + ofd_pkg::DIM_W'(1)) < cfg.height;
  assign left_ok  = ocol_r != '0;
  assign right_ok = !col_last;

  always_comb begin
    frontier = 1'b0;
    for (int dr = 0; dr < 3; dr++) begin
      for (int dc = 0; dc < 3; dc++) begin
        if (!(dr == 0 && !top_ok) && !(dr == 2 && !bot_ok) &&
            !(dc == 0 && !left_ok) && !(dc == 2 && !right_ok) &&
            (win_nxt[dr*3 + dc] == cfg.free_code)) begin
          frontier = 1'b1;
        end
      end
    end
    if (win_nxt[4] != cfg.unknown_code) begin
      frontier = 1'b0;
    end
  end

  always_comb begin
    ocol_nxt = ocol_r;
    orow_nxt = orow_r;
    if (produce) begin
      if (col_last) begin
        ocol_nxt = '0;
        orow_nxt = orow_r + ofd_pkg::DIM_W'(1);
      end else begin
        ocol_nxt = ocol_r + ofd_pkg::COL_W'(1);
      end
    end
    if (produce) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
      ocol_r      <= '0;
      orow_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        for (int i = 0; i < 9; i++) begin
          win_r[i] <= win_nxt[i];
        end
      end
      ocol_r      <= ocol_nxt;
      orow_r      <= orow_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      out_column_r   <= ofd_pkg::COLUMN_W'(ocol_r);
      out_row_r      <= ofd_pkg::ROW_W'(orow_r);
      out_frontier_r <= frontier;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_column      = out_column_r;
  assign out_row         = out_row_r;
  assign out_is_frontier = out_frontier_r;

endmodule

### rtl/core/occupancy_frontier_detect_unit.sv
// Top level of the occupancy frontier detector: input raster counters, line buffer and wiring.
//
//  Channel  Ports                                         Moves
//  in       in_valid, in_stall, in_cell_value, in_pad     one grid cell or pad per transfer
//  out      out_valid, out_stall, out_column, out_row,    one reported centre cell per transfer
//           out_is_frontier
//  cfg      cfg_psel, cfg_penable, cfg_pwrite, cfg_paddr, register write and read access
//           cfg_pwdata, cfg_prdata, cfg_pready
//
// One cell is accepted per cycle while in_stall is low; the cell that completes a window is held in
// the s1 register and its result is then loaded into the output register.
// The line buffer is one RAM holding both previous rows, read and written once per cell.
// Reset is synchronous and active low; no clearing pass is needed after reset.
// A stalled output stops the window stage and then the input, with no loss of data.
module occupancy_frontier_detect_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ofd_pkg::CELL_W-1:0]    in_cell_value,
  input  logic                          in_pad,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ofd_pkg::COLUMN_W-1:0]  out_column,
  output logic [ofd_pkg::ROW_W-1:0]     out_row,
  output logic                          out_is_frontier,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [ofd_pkg::PADDR_W-1:0]   cfg_paddr,
  input  logic [ofd_pkg::PDATA_W-1:0]   cfg_pwdata,
  output logic [ofd_pkg::PDATA_W-1:0]   cfg_prdata,
  output logic                          cfg_pready
);

  ofd_pkg::cfg_t                  cfg;
  ofd_pkg::scan_t                 s1_r, s1_nxt;
  logic [ofd_pkg::COL_W-1:0]      in_col_r, in_col_nxt;
  logic [ofd_pkg::IN_ROW_W-1:0]   in_row_r, in_row_nxt;
  logic [ofd_pkg::COL_W-1:0]      ic;
  logic [ofd_pkg::IN_ROW_W-1:0]   ir;
  logic                           col_wrap;
  logic                           accept;
  logic                           s1_ready;
  logic                           s1_fire;
  logic [ofd_pkg::LINE_W-1:0]     ram_rdata;
  logic [ofd_pkg::LINE_W-1:0]     col_data;
  logic [ofd_pkg::LINE_W-1:0]     wr_data;
  logic                           fwd_hit_r;
  logic [ofd_pkg::LINE_W-1:0]     fwd_data_r;

  ofd_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  assign in_stall = s1_r.valid && !s1_ready;
  assign accept   = in_valid && !in_stall;
  assign s1_fire  = s1_r.valid && s1_ready;

  // A column left beyond a narrowed width starts the next row first.
  assign col_wrap = ofd_pkg::DIM_W'(in_col_r) >= cfg.width;
  assign ic       = col_wrap ? '0 : in_col_r;
  assign ir       = (col_wrap && in_row_r != '1) ? in_row_r + ofd_pkg::IN_ROW_W'(1) : in_row_r;

  always_comb begin
    in_col_nxt = in_col_r;
    in_row_nxt = in_row_r;
    s1_nxt     = s1_r;
    if (accept) begin
      if ((ofd_pkg::DIM_W'(ic) + ofd_pkg::DIM_W'(1)) >= cfg.width) begin
        in_col_nxt = '0;
        in_row_nxt = (ir != '1) ? ir + ofd_pkg::IN_ROW_W'(1) : ir;
      end else begin
        in_col_nxt = ic + ofd_pkg::COL_W'(1);
        in_row_nxt = ir;
      end
      s1_nxt.valid = 1'b1;
      s1_nxt.col   = ic;
      s1_nxt.value = in_pad ? '0 : in_cell_value;
      s1_nxt.due   = (ir >= ofd_pkg::IN_ROW_W'(2)) ||
                     (ir == ofd_pkg::IN_ROW_W'(1) && ic != '0);
    end else if (s1_fire) begin
      s1_nxt.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      s1_r      <= '0;
      fwd_hit_r <= 1'b0;
    end else begin
      in_col_r <= in_col_nxt;
      in_row_r <= in_row_nxt;
      s1_r     <= s1_nxt;
      if (accept) begin
        fwd_hit_r <= s1_fire && (s1_r.col == ic);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_data_r <= wr_data;
    end
  end

  // The entry keeps the two rows above: upper byte two rows up, lower byte one row up.
  assign col_data = fwd_hit_r ? fwd_data_r : ram_rdata;
  assign wr_data  = {col_data[ofd_pkg::CELL_W-1:0], s1_r.value};

  ofd_ram #(
    .Width (ofd_pkg::LINE_W),
    .Depth (ofd_pkg::MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_r.col),
    .wdata (wr_data),
    .re    (accept),
    .raddr (ic),
    .rdata (ram_rdata)
  );

  ofd_window u_window (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .s1              (s1_r),
    .col_data        (col_data),
    .s1_ready        (s1_ready),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_column      (out_column),
    .out_row         (out_row),
    .out_is_frontier (out_is_frontier)
  );

endmodule

### rtl/core/ofd_checker.sv
// Port-level assertion checker for the occupancy frontier detector, bound to the top level.
module ofd_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [ofd_pkg::COLUMN_W-1:0]  out_column,
  input logic [ofd_pkg::ROW_W-1:0]     out_row,
  input logic                          out_is_frontier
);

  // Reset empties the output register.
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

  // The input only backs up when a result is waiting on a stalled output.
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a stalled output");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_column) && $stable(out_row) && $stable(out_is_frontier)))
    else $error("stalled output changed");

endmodule

bind occupancy_frontier_detect_unit ofd_checker u_ofd_checker (.*);
